@@ hdl/sf_pkg.sv @@
package sf_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET_MIX       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LFO_DEPTH     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_GAIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_SHIFT   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LFO_AMPLITUDE = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_RATE   = 3'd6;
   localparam int CSR_DATA_BITS = 27;

   // register reset values
   localparam logic [16:0] WET_MIX_RST       = 17'd19661;
   localparam logic [16:0] LFO_DEPTH_RST     = 17'd19661;
   localparam logic [26:0] PHASE_STEP_RST    = 27'd44739;
   localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd13107;
   localparam logic [15:0] PHASE_SHIFT_RST   = 16'd0;
   localparam logic [15:0] LFO_AMPLITUDE_RST = 16'd16384;
   localparam logic [17:0] SAMPLE_RATE_RST   = 18'd48000;

   // sine polynomial, taylor terms of sin(pi/2*u) in q2.30
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] SIN_A1  = 64'd1686629713;
   localparam logic [63:0] SIN_A3  = 64'd693598668;
   localparam logic [63:0] SIN_A5  = 64'd85569306;
   localparam logic [63:0] SIN_A7  = 64'd5026996;

   // delay mapping: 3 ms center (q2.30), 2 ms span and 0.001 smoothing (q0.32)
   localparam logic signed [31:0] MAP_CENTER = 32'sd3221225;
   localparam logic signed [24:0] MAP_SPAN   = 25'sd8589935;
   localparam logic signed [23:0] SMOOTH_K   = 24'sd4294967;
   localparam logic signed [31:0] DELAY_RST  = 32'sd1073741824;

   // per-step strobes from the sequencer to each channel lane
   typedef struct packed {
      logic load;
      logic wr_en;
      logic rd_en;
      logic cap_a;
      logic a_ok;
      logic cap_b;
      logic b_ok;
      logic do_diff;
      logic do_interp;
      logic do_mix;
      logic do_out;
   } lane_ctl_type;

endpackage

@@ hdl/sf_ram.sv @@
module sf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/sf_lfo.sv @@
module sf_lfo #(
   parameter int RING_DEPTH = 2048,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [26:0]                   phase_step,
   input  logic [15:0]                   phase_shift,
   input  logic [15:0]                   lfo_amplitude,
   input  logic [16:0]                   lfo_depth,
   input  logic [17:0]                   sample_rate,
   input  logic [$clog2(RING_DEPTH)-1:0] wr_ptr,
   output logic [$clog2(RING_DEPTH)-1:0] rd_ptr,
   output logic [29:0]                   frac,
   output logic                          done
);

   localparam int PTR_BITS  = $clog2(RING_DEPTH);
   localparam int SINE_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int POS_BITS  = PTR_BITS + 32;
   localparam int DCL_BITS  = PTR_BITS + 30;
   localparam int NSTAGE    = 10;
   localparam logic signed [50:0] DELAY_MAX = 51'(RING_DEPTH - 1) << 30;

   typedef logic signed [31:0] rom_type [SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type    rom;
      logic [63:0] p;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] t;
      logic [63:0] s;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         p = (64'(k) << (32 - SINE_BITS)) & 64'hFFFF_FFFF;
         u = p & (sf_pkg::Q30_ONE - 64'd1);
         if (p[30]) begin
            u = sf_pkg::Q30_ONE - u;
         end
         u2 = (u * u) >> 30;
         t  = sf_pkg::SIN_A7;
         t  = sf_pkg::SIN_A5 - ((u2 * t) >> 30);
         t  = sf_pkg::SIN_A3 - ((u2 * t) >> 30);
         t  = sf_pkg::SIN_A1 - ((u2 * t) >> 30);
         s  = (u * t) >> 30;
         if (s > sf_pkg::Q30_ONE) begin
            s = sf_pkg::Q30_ONE;
         end
         rom[k] = p[31] ? -$signed(32'(s)) : $signed(32'(s));
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [NSTAGE-1:0]      stage_ff, stage_in;
   logic [31:0]            phase_ff, phase_in;
   logic signed [31:0]     smooth_ff, smooth_in;
   logic [31:0]            total;
   logic signed [31:0]     sine_ff;
   logic signed [34:0]     p1_ff;
   logic signed [36:0]     p2_ff;
   logic signed [31:0]     tgt_ff;
   logic signed [32:0]     diff_ff;
   logic signed [50:0]     dsamp_ff;
   logic [DCL_BITS-1:0]    dcl_ff;
   logic [PTR_BITS-1:0]    rd_ptr_ff;
   logic [29:0]            frac_ff;
   logic signed [48:0]     prod1;
   logic signed [52:0]     prod2;
   logic signed [61:0]     prod3;
   logic signed [56:0]     prod4;
   logic signed [50:0]     prod5;
   logic [PTR_BITS:0]      wrap_ptr;
   logic signed [POS_BITS-1:0] pos_a, pos_b, pos;

   assign stage_in = {stage_ff[NSTAGE-2:0], start};
   assign total    = phase_ff + {phase_shift, 16'd0};
   assign phase_in = stage_ff[0] ? phase_ff + 32'(phase_step) : phase_ff;

   assign prod1 = 49'(sine_ff) * 49'($signed({1'b0, lfo_amplitude}));
   assign prod2 = 53'(p1_ff) * 53'($signed({1'b0, lfo_depth}));
   assign prod3 = 62'(p2_ff) * 62'(sf_pkg::MAP_SPAN);
   assign prod4 = 57'(diff_ff) * 57'(sf_pkg::SMOOTH_K);
   assign prod5 = 51'(smooth_ff) * 51'($signed({1'b0, sample_rate}));

   assign smooth_in = stage_ff[5] ? smooth_ff - 32'($signed(prod4[56:32])) : smooth_ff;

   // candidate positions with and without the ring wrap, picked by sign
   assign wrap_ptr = {1'b0, wr_ptr} + (PTR_BITS + 1)'(RING_DEPTH);
   assign pos_a = $signed({2'b00, wr_ptr, 30'd0}) - $signed({2'b00, dcl_ff});
   assign pos_b = $signed({1'b0, wrap_ptr, 30'd0}) - $signed({2'b00, dcl_ff});
   assign pos   = pos_a[POS_BITS-1] ? pos_b : pos_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= '0;
         phase_ff  <= '0;
         smooth_ff <= sf_pkg::DELAY_RST;
      end else begin
         stage_ff  <= stage_in;
         phase_ff  <= phase_in;
         smooth_ff <= smooth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ff[0]) begin
         sine_ff <= SINE_ROM[total[31 -: SINE_BITS]];
      end
      if (stage_ff[1]) begin
         p1_ff <= $signed(prod1[48:14]);
      end
      if (stage_ff[2]) begin
         p2_ff <= $signed(prod2[52:16]);
      end
      if (stage_ff[3]) begin
         tgt_ff <= 32'($signed(prod3[61:32])) + sf_pkg::MAP_CENTER;
      end
      if (stage_ff[4]) begin
         diff_ff <= 33'(smooth_ff) - 33'(tgt_ff);
      end
      if (stage_ff[6]) begin
         dsamp_ff <= prod5;
      end
      if (stage_ff[7]) begin
         if (dsamp_ff < 0) begin
            dcl_ff <= '0;
         end else if (dsamp_ff > DELAY_MAX) begin
            dcl_ff <= DELAY_MAX[DCL_BITS-1:0];
         end else begin
            dcl_ff <= dsamp_ff[DCL_BITS-1:0];
         end
      end
      if (stage_ff[8]) begin
         rd_ptr_ff <= pos[PTR_BITS+29:30];
         frac_ff   <= pos[29:0];
      end
   end

   assign rd_ptr = rd_ptr_ff;
   assign frac   = frac_ff;
   assign done   = stage_ff[NSTAGE-1];

endmodule

@@ hdl/sf_lane.sv @@
module sf_lane #(
   parameter int RING_DEPTH = 2048,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sf_pkg::lane_ctl_type          ctl,
   input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
   input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   input  logic [29:0]                   frac,
   input  logic [16:0]                   wet_mix,
   input  logic [15:0]                   feedback_gain,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   localparam int SB = SAMPLE_BITS;
   localparam logic signed [SB+2:0] SMAX = (SB+3)'((64'd1 << (SB - 1)) - 64'd1);
   localparam logic signed [SB+2:0] SMIN = -SMAX - (SB+3)'(1);

   logic signed [SB-1:0]  in_ff, fb_ff, fb_in, a_ff, b_ff, dl_ff, out_ff;
   logic signed [SB:0]    diff_ff;
   logic signed [SB+17:0] mixa_ff, mixb_ff;
   logic signed [SB+2:0]  wr_sum, out_sum;
   logic signed [SB-1:0]  wr_data, out_sat;
   logic [SB-1:0]         rdata;
   logic signed [SB+31:0] prod_i;
   logic signed [SB+16:0] prod_f;
   logic signed [17:0]    wet_s, dry_s;
   logic signed [SB+18:0] mix_sum;

   // ring write, input plus feedback saturated
   assign wr_sum  = (SB+3)'(in_ff) + (SB+3)'(fb_ff);
   assign wr_data = (wr_sum > SMAX) ? SMAX[SB-1:0] :
                    (wr_sum < SMIN) ? SMIN[SB-1:0] : wr_sum[SB-1:0];

   sf_ram #(
      .WIDTH(SB),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock(clock),
      .we   (ctl.wr_en),
      .waddr(wr_addr),
      .wdata(wr_data),
      .re   (ctl.rd_en),
      .raddr(rd_addr),
      .rdata(rdata)
   );

   assign prod_i = (SB+32)'(diff_ff) * (SB+32)'($signed({1'b0, frac}));
   assign prod_f = (SB+17)'(dl_ff) * (SB+17)'($signed({1'b0, feedback_gain}));
   assign fb_in  = prod_f[SB+15:16];
   assign wet_s  = $signed({1'b0, wet_mix});
   assign dry_s  = 18'sd65536 - wet_s;

   assign mix_sum = (SB+19)'(mixa_ff) + (SB+19)'(mixb_ff);
   assign out_sum = $signed(mix_sum[SB+18:16]);
   assign out_sat = (out_sum > SMAX) ? SMAX[SB-1:0] :
                    (out_sum < SMIN) ? SMIN[SB-1:0] : out_sum[SB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff <= '0;
      end else if (ctl.do_mix) begin
         fb_ff <= fb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         in_ff <= sample_in;
      end
      // never-written ring entries read as zero
      if (ctl.cap_a) begin
         a_ff <= ctl.a_ok ? $signed(rdata) : '0;
      end
      if (ctl.cap_b) begin
         b_ff <= ctl.b_ok ? $signed(rdata) : '0;
      end
      if (ctl.do_diff) begin
         diff_ff <= (SB+1)'(b_ff) - (SB+1)'(a_ff);
      end
      if (ctl.do_interp) begin
         dl_ff <= a_ff + SB'($signed(prod_i[SB+31:30]));
      end
      if (ctl.do_mix) begin
         mixa_ff <= (SB+18)'(in_ff) * (SB+18)'(dry_s);
         mixb_ff <= (SB+18)'(dl_ff) * (SB+18)'(wet_s);
      end
      if (ctl.do_out) begin
         out_ff <= out_sat;
      end
   end

   assign sample_out = out_ff;

endmodule

@@ hdl/stereo_flanger.sv @@
// Stereo flanger with feedback. Each transfer on req_ carries one signed stereo pair and
// yields exactly one mixed pair on rsp_. A table sine LFO (phase plus phase offset) is scaled
// by amplitude and depth, mapped onto a 1..5 ms delay, smoothed by a one-pole filter and
// turned into a fractional sample delay by sample_rate. Both channels run in identical lanes
// side by side: each writes input plus feedback into its own ring, reads two neighboring
// entries, interpolates, and forms feedback and the dry/wet mix. One pair is in flight at a
// time and passes through the 10-step delay calculation followed by two ring reads and the
// interpolate / mix steps. A new pair is taken while the previous result still waits on
// rsp_. The rings need no clearing after reset: entries not yet written since reset read as
// zero. Configuration registers are written through csr_we / csr_index / csr_wdata; the user
// must do so only while no pair is in flight, which the block itself does not enforce.
module stereo_flanger #(
   parameter int RING_DEPTH = 2048,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]         req_right_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]         rsp_right_out,
   input  logic                                  csr_we,
   input  logic [sf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sf_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int PTR_BITS = $clog2(RING_DEPTH);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(RING_DEPTH - 1);

   // one-hot sequencer
   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_WRITE    = 10'b00_0000_0010,
      ST_LFO_WAIT = 10'b00_0000_0100,
      ST_RD_A     = 10'b00_0000_1000,
      ST_RD_B     = 10'b00_0001_0000,
      ST_CAP_B    = 10'b00_0010_0000,
      ST_DIFF     = 10'b00_0100_0000,
      ST_INTERP   = 10'b00_1000_0000,
      ST_MIX      = 10'b01_0000_0000,
      ST_FINISH   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [16:0] wet_mix_ff;
   logic [16:0] lfo_depth_ff;
   logic [26:0] phase_step_ff;
   logic [15:0] feedback_gain_ff;
   logic [15:0] phase_shift_ff;
   logic [15:0] lfo_amplitude_ff;
   logic [17:0] sample_rate_ff;

   logic [PTR_BITS-1:0] wp_ff, wp_in;
   logic                wrapped_ff, wrapped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_xfer, out_free;
   logic                lfo_done;
   logic [PTR_BITS-1:0] rd_ptr, rd_ptr1, rd_addr;
   logic [29:0]         frac;
   sf_pkg::lane_ctl_type ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // second interpolation tap wraps to the start of the ring
   assign rd_ptr1 = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_BITS'(1);
   assign rd_addr = (state_ff == ST_RD_A) ? rd_ptr : rd_ptr1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_mix_ff       <= sf_pkg::WET_MIX_RST;
         lfo_depth_ff     <= sf_pkg::LFO_DEPTH_RST;
         phase_step_ff    <= sf_pkg::PHASE_STEP_RST;
         feedback_gain_ff <= sf_pkg::FEEDBACK_GAIN_RST;
         phase_shift_ff   <= sf_pkg::PHASE_SHIFT_RST;
         lfo_amplitude_ff <= sf_pkg::LFO_AMPLITUDE_RST;
         sample_rate_ff   <= sf_pkg::SAMPLE_RATE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            sf_pkg::CSR_WET_MIX:       wet_mix_ff       <= csr_wdata[16:0];
            sf_pkg::CSR_LFO_DEPTH:     lfo_depth_ff     <= csr_wdata[16:0];
            sf_pkg::CSR_PHASE_STEP:    phase_step_ff    <= csr_wdata[26:0];
            sf_pkg::CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_wdata[15:0];
            sf_pkg::CSR_PHASE_SHIFT:   phase_shift_ff   <= csr_wdata[15:0];
            sf_pkg::CSR_LFO_AMPLITUDE: lfo_amplitude_ff <= csr_wdata[15:0];
            sf_pkg::CSR_SAMPLE_RATE:   sample_rate_ff   <= csr_wdata[17:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // sequencer next state and lane strobes
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      ctl.load     = req_xfer;
      // an entry is live once written: everything after the first lap, else up to the
      // write pointer (the current sample included)
      ctl.a_ok     = wrapped_ff || (rd_ptr <= wp_ff);
      ctl.b_ok     = wrapped_ff || (rd_ptr1 <= wp_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ctl.wr_en = 1'b1;
            state_in  = ST_LFO_WAIT;
         end
         ST_LFO_WAIT: begin
            if (lfo_done) begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_RD_B;
         end
         ST_RD_B: begin
            ctl.rd_en = 1'b1;
            ctl.cap_a = 1'b1;
            state_in  = ST_CAP_B;
         end
         ST_CAP_B: begin
            ctl.cap_b = 1'b1;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            ctl.do_diff = 1'b1;
            state_in    = ST_INTERP;
         end
         ST_INTERP: begin
            ctl.do_interp = 1'b1;
            state_in      = ST_MIX;
         end
         ST_MIX: begin
            ctl.do_mix = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold here while the previous result is still unclaimed
            if (out_free) begin
               ctl.do_out   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (wp_ff == PTR_LAST) begin
                  wp_in      = '0;
                  wrapped_in = 1'b1;
               end else begin
                  wp_in = wp_ff + PTR_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // shared delay path: lfo, smoothing, ring position
   sf_lfo #(
      .RING_DEPTH      (RING_DEPTH),
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_lfo (
      .clock        (clock),
      .reset        (reset),
      .start        (req_xfer),
      .phase_step   (phase_step_ff),
      .phase_shift  (phase_shift_ff),
      .lfo_amplitude(lfo_amplitude_ff),
      .lfo_depth    (lfo_depth_ff),
      .sample_rate  (sample_rate_ff),
      .wr_ptr       (wp_ff),
      .rd_ptr       (rd_ptr),
      .frac         (frac),
      .done         (lfo_done)
   );

   // left and right lanes share the strobes and the read position
   sf_lane #(
      .RING_DEPTH (RING_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_lane_left (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .wr_addr      (wp_ff),
      .rd_addr      (rd_addr),
      .frac         (frac),
      .wet_mix      (wet_mix_ff),
      .feedback_gain(feedback_gain_ff),
      .sample_in    (req_left_in),
      .sample_out   (rsp_left_out)
   );

   sf_lane #(
      .RING_DEPTH (RING_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_lane_right (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .wr_addr      (wp_ff),
      .rd_addr      (rd_addr),
      .frac         (frac),
      .wet_mix      (wet_mix_ff),
      .feedback_gain(feedback_gain_ff),
      .sample_in    (req_right_in),
      .sample_out   (rsp_right_out)
   );

`ifndef SYNTHESIS
   // delay path finishes only while the sequencer waits for it
   a_lfo_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      lfo_done |-> (state_ff == ST_LFO_WAIT))
      else $error("delay path done outside wait state");

   // a request transfer always starts with the ring write
   a_xfer_to_write: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_WRITE))
      else $error("request transfer did not start a ring write");

   // a new result appears only from the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish step");

   // write pointer moves only when a result is handed over
   a_wp_moves_on_out: assert property (@(posedge clock) disable iff (reset)
      !$past(ctl.do_out) && !$past(reset) |-> $stable(wp_ff))
      else $error("write pointer moved without a result");
`endif

endmodule

@@ test/stereo_flanger_check.sv @@
`timescale 1ns / 1ps

module stereo_flanger_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [23:0]                req_left_in,
   input  logic signed [23:0]                req_right_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [23:0]                rsp_left_out,
   input  logic signed [23:0]                rsp_right_out,
   input  logic                              csr_we,
   input  logic [sf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sf_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                mismatches,
   output int                                outstanding,
   output int                                pairs_checked
);

   localparam int DEPTH = 2048;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
   } pair_type;

   pair_type mixed_q[$];

   logic [16:0] wet_r, depth_r;
   logic [26:0] step_r;
   logic [15:0] gain_r, shift_r, amp_r;
   logic [17:0] rate_r;

   longint sine_tab[256];
   logic signed [23:0] left_line[DEPTH];
   logic signed [23:0] right_line[DEPTH];
   int unsigned wr_ptr;
   logic [31:0] phase;
   longint delay_q30, left_fb, right_fb;

   function automatic logic signed [23:0] clip24(longint v);
      if (v > 64'sd8388607) return 24'sh7fffff;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   // quarter-wave polynomial sine in q2.30
   initial begin
      for (int k = 0; k < 256; k++) begin
         logic [31:0] p;
         longint unsigned u, u2, t, s;
         p = k << 24;
         u = 64'(p[29:0]);
         if (p[30]) u = (64'd1 << 30) - u;
         u2 = (u * u) >> 30;
         t = sf_pkg::SIN_A7;
         t = sf_pkg::SIN_A5 - ((u2 * t) >> 30);
         t = sf_pkg::SIN_A3 - ((u2 * t) >> 30);
         t = sf_pkg::SIN_A1 - ((u2 * t) >> 30);
         s = (u * t) >> 30;
         if (s > sf_pkg::Q30_ONE) s = sf_pkg::Q30_ONE;
         sine_tab[k] = p[31] ? -longint'(s) : longint'(s);
      end
   end

   function automatic pair_type flange(logic signed [23:0] lin, logic signed [23:0] rin);
      pair_type res;
      logic [31:0] total;
      longint lfo, target, dsamp, pos, frac, a, b, dl, dr, wet;
      int unsigned x, x1;
      total = phase + {shift_r, 16'd0};
      lfo = (sine_tab[total[31:24]] * longint'(amp_r)) >>> 14;
      lfo = (lfo * longint'(depth_r)) >>> 16;
      phase = phase + step_r;
      target = 64'sd3221225 + ((lfo * 64'sd8589935) >>> 32);
      delay_q30 = delay_q30 - (((delay_q30 - target) * 64'sd4294967) >>> 32);
      dsamp = delay_q30 * longint'(rate_r);
      // delay clamped into the ring
      if (dsamp < 0) dsamp = 0;
      if (dsamp > (longint'(DEPTH - 1) << 30)) dsamp = longint'(DEPTH - 1) << 30;
      left_line[wr_ptr] = clip24(longint'(lin) + left_fb);
      right_line[wr_ptr] = clip24(longint'(rin) + right_fb);
      pos = (longint'(wr_ptr) << 30) - dsamp;
      if (pos < 0) pos += longint'(DEPTH) << 30;
      x = 32'(pos >>> 30);
      frac = pos & ((64'sd1 << 30) - 1);
      if (x >= DEPTH) x -= DEPTH;
      x1 = (x + 1 >= DEPTH) ? 0 : x + 1;
      a = left_line[x];
      b = left_line[x1];
      dl = a + (((b - a) * frac) >>> 30);
      a = right_line[x];
      b = right_line[x1];
      dr = a + (((b - a) * frac) >>> 30);
      left_fb = (dl * longint'(gain_r)) >>> 16;
      right_fb = (dr * longint'(gain_r)) >>> 16;
      wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
      wet = longint'(wet_r);
      res.left = clip24((longint'(lin) * (65536 - wet) + dl * wet) >>> 16);
      res.right = clip24((longint'(rin) * (65536 - wet) + dr * wet) >>> 16);
      return res;
   endfunction

   always @(posedge clock) begin
      pair_type want;
      if (reset) begin
         wet_r <= sf_pkg::WET_MIX_RST;
         depth_r <= sf_pkg::LFO_DEPTH_RST;
         step_r <= sf_pkg::PHASE_STEP_RST;
         gain_r <= sf_pkg::FEEDBACK_GAIN_RST;
         shift_r <= sf_pkg::PHASE_SHIFT_RST;
         amp_r <= sf_pkg::LFO_AMPLITUDE_RST;
         rate_r <= sf_pkg::SAMPLE_RATE_RST;
         for (int i = 0; i < DEPTH; i++) begin
            left_line[i] = '0;
            right_line[i] = '0;
         end
         wr_ptr = 0;
         phase = '0;
         delay_q30 = 64'sd1 << 30;
         left_fb = 0;
         right_fb = 0;
         mixed_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               sf_pkg::CSR_WET_MIX:       wet_r <= csr_wdata[16:0];
               sf_pkg::CSR_LFO_DEPTH:     depth_r <= csr_wdata[16:0];
               sf_pkg::CSR_PHASE_STEP:    step_r <= csr_wdata[26:0];
               sf_pkg::CSR_FEEDBACK_GAIN: gain_r <= csr_wdata[15:0];
               sf_pkg::CSR_PHASE_SHIFT:   shift_r <= csr_wdata[15:0];
               sf_pkg::CSR_LFO_AMPLITUDE: amp_r <= csr_wdata[15:0];
               sf_pkg::CSR_SAMPLE_RATE:   rate_r <= csr_wdata[17:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            mixed_q.push_back(flange(req_left_in, req_right_in));
         if (rsp_valid && rsp_ready) begin
            pairs_checked++;
            if (mixed_q.size() == 0) begin
               $error("unexpected transfer: left_out %0d right_out %0d",
                      rsp_left_out, rsp_right_out);
               mismatches++;
            end else begin
               want = mixed_q.pop_front();
               if (rsp_left_out !== want.left) begin
                  $error("left_out: expected %0d, actual %0d", want.left, rsp_left_out);
                  mismatches++;
               end
               if (rsp_right_out !== want.right) begin
                  $error("right_out: expected %0d, actual %0d", want.right, rsp_right_out);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= mixed_q.size();
   end

   initial begin
      mismatches = 0;
      outstanding = 0;
      pairs_checked = 0;
   end

endmodule

@@ test/stereo_flanger_test.sv @@
`timescale 1ns / 1ps

module stereo_flanger_test;

   // index past the register list, writes to it must be dropped
   localparam logic [sf_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASES = 8;
   localparam int RANDOM_PER_PHASE = 204;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [23:0] req_left_in = '0;
   logic signed [23:0] req_right_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [23:0] rsp_left_out, rsp_right_out;
   logic csr_we = 1'b0;
   logic [sf_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [sf_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   int mismatches, outstanding, pairs_checked;
   int pairs_sent = 0;
   int quiet_cycles = 0;
   int rx_cycle = 0;
   bit tx_gaps = 1'b1;

   always #10 clock = ~clock;

   stereo_flanger dut (.*);

   stereo_flanger_check checker_i (.*);

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off so the block backs up, one clean stretch
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (reset)
         rsp_ready <= 1'b0;
      else if (rx_cycle >= 3000 && rx_cycle < 3300)
         rsp_ready <= 1'b0;
      else if (rx_cycle >= 9000 && rx_cycle < 13000)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= 27);
   end

   // one stereo transfer, called at a rising edge; valid stays up across back-to-back pairs
   task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
      req_valid <= 1'b1;
      req_left_in <= l;
      req_right_in <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pairs_sent++;
      if (tx_gaps && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic signed [23:0] pick_sample();
      case ($urandom_range(9))
         0: return 24'sh7fffff;
         1: return 24'sh800000;
         2, 3: return $signed(24'($urandom_range(4095))) - 24'sd2048;
         default: return 24'($urandom);
      endcase
   endfunction

   // let the block drain before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic csr_write(logic [sf_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [sf_pkg::CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_setting(int p);
      case (p)
         1: begin
            // upper ends of the ranges
            csr_write(sf_pkg::CSR_WET_MIX, 27'd65536);
            csr_write(sf_pkg::CSR_LFO_DEPTH, 27'd65536);
            csr_write(sf_pkg::CSR_PHASE_STEP, 27'd67108864);
            csr_write(sf_pkg::CSR_FEEDBACK_GAIN, 27'd64880);
            csr_write(sf_pkg::CSR_PHASE_SHIFT, 27'd52150);
            csr_write(sf_pkg::CSR_LFO_AMPLITUDE, 27'd49152);
            csr_write(sf_pkg::CSR_SAMPLE_RATE, 27'd192000);
         end
         2: begin
            // lower ends
            csr_write(sf_pkg::CSR_WET_MIX, 27'd0);
            csr_write(sf_pkg::CSR_LFO_DEPTH, 27'd0);
            csr_write(sf_pkg::CSR_PHASE_STEP, 27'd0);
            csr_write(sf_pkg::CSR_FEEDBACK_GAIN, 27'd655);
            csr_write(sf_pkg::CSR_PHASE_SHIFT, 27'd0);
            csr_write(sf_pkg::CSR_LFO_AMPLITUDE, 27'd164);
            csr_write(sf_pkg::CSR_SAMPLE_RATE, 27'd8000);
         end
         3: begin
            // all-ones fields: wet above unity, delay clamped to ring, masked upper bits
            csr_write(sf_pkg::CSR_WET_MIX, '1);
            csr_write(sf_pkg::CSR_LFO_DEPTH, '1);
            csr_write(sf_pkg::CSR_PHASE_STEP, '1);
            csr_write(sf_pkg::CSR_FEEDBACK_GAIN, '1);
            csr_write(sf_pkg::CSR_PHASE_SHIFT, '1);
            csr_write(sf_pkg::CSR_LFO_AMPLITUDE, '1);
            csr_write(sf_pkg::CSR_SAMPLE_RATE, '1);
         end
         4: begin
            // zero sample rate means zero delay
            csr_write(sf_pkg::CSR_SAMPLE_RATE, 27'd0);
            csr_write(sf_pkg::CSR_WET_MIX, 27'd32768);
            csr_write(sf_pkg::CSR_FEEDBACK_GAIN, 27'd40000);
         end
         7: begin
            csr_write(sf_pkg::CSR_WET_MIX, 27'd19661);
            csr_write(sf_pkg::CSR_SAMPLE_RATE, 27'd48000);
            csr_write(CSR_UNUSED, '1);
         end
         default: begin
            csr_write(sf_pkg::CSR_WET_MIX, 27'($urandom_range(65536)));
            csr_write(sf_pkg::CSR_LFO_DEPTH, 27'($urandom_range(65536)));
            csr_write(sf_pkg::CSR_PHASE_STEP, 27'($urandom_range(67108864)));
            csr_write(sf_pkg::CSR_FEEDBACK_GAIN, 27'($urandom_range(64880, 655)));
            csr_write(sf_pkg::CSR_PHASE_SHIFT, 27'($urandom_range(52150)));
            csr_write(sf_pkg::CSR_LFO_AMPLITUDE, 27'($urandom_range(49152, 164)));
            csr_write(sf_pkg::CSR_SAMPLE_RATE, 27'($urandom_range(192000, 8000)));
         end
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed extremes at reset settings
      send_pair(24'sd0, 24'sd0);
      send_pair(24'sh7fffff, 24'sh7fffff);
      send_pair(24'sh800000, 24'sh800000);
      send_pair(24'sh7fffff, 24'sh800000);
      send_pair(24'sh800000, 24'sh7fffff);
      send_pair(24'sd1, -24'sd1);
      repeat (6) send_pair(24'sh7fffff, 24'sh7fffff);

      for (int p = 1; p < PHASES; p++) begin
         wait_idle();
         apply_setting(p);
         tx_gaps = (p != 5);
         // feedback pushes the ring write into saturation
         if (p == 3) begin
            repeat (6) send_pair(24'sh7fffff, 24'sh800000);
            repeat (6) send_pair(24'sh800000, 24'sh7fffff);
         end
         for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_pair(pick_sample(), pick_sample());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d stereo pairs over %0d register settings, checked %0d results",
               pairs_sent, PHASES, pairs_checked);
      if (mismatches == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
